/* rtl/bchd_pkg.sv */
// shared types and constants of the button click / hold detector
// used by bchd_ctrl, bchd_dp and button_click_hold_detector; no dependencies
`default_nettype none

package bchd_pkg;

	localparam int unsigned CFG_W  = 16;
	localparam int unsigned CIDX_W = 2;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned PROG_W = 17;
	localparam int unsigned CMD_W  = 3;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_WINDOW    = 2'd0;
	localparam logic [CIDX_W-1:0] REG_THRESHOLD = 2'd1;
	localparam logic [CIDX_W-1:0] REG_DELAY     = 2'd2;

	// reset values of the configuration registers
	localparam logic [CFG_W-1:0] WINDOW_RST    = 16'd300;
	localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd3000;
	localparam logic [CFG_W-1:0] DELAY_RST     = 16'd500;

	// command codes
	localparam logic [CMD_W-1:0] CMD_NONE     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POWEROFF = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PAIRING  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LOCK     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_MIRROR   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SHOOT    = 3'd5;

	localparam logic [PROG_W-1:0] Q16_ONE = 17'h10000;

	// one quotient bit per divider step
	localparam int unsigned DIV_STEPS = CFG_W;
	localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);
	localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_STEPS - 1);

	typedef struct packed {
		logic capture;
		logic eval;
		logic prep;
		logic div_step;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic div_last;
	} dp_sts_t;

endpackage

`default_nettype wire

/* rtl/bchd_ctrl.sv */
// controller state machine of the button click / hold detector
// depends on bchd_pkg; drives the datapath commands and both handshakes
`default_nettype none

module bchd_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  wire               out_stall,
	output bchd_pkg::dp_cmd_t cmd,
	input  bchd_pkg::dp_sts_t sts
);
	import bchd_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EVAL = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// an accepted sample goes straight to evaluation
	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_EVAL))
		else $error("accepted sample did not enter evaluation");

	// the last divider step leads to the result hand-off
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && sts.div_last) |=> (state_q == ST_DONE))
		else $error("divider finish not followed by result hand-off");

	// a new result only appears out of the hand-off state
	a_rose_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result valid raised outside hand-off");

	// a stalled result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !cmd.load_out)
		else $error("output register loaded while result stalled");

endmodule

`default_nettype wire

/* rtl/bchd_dp.sv */
// datapath of the button click / hold detector: config registers, button
// state, event evaluation, serial progress divider, output register; uses bchd_pkg
`default_nettype none

module bchd_dp (
	input  wire                          clk,
	input  wire                          arst_n,
	input  bchd_pkg::dp_cmd_t            cmd,
	output bchd_pkg::dp_sts_t            sts,
	input  wire                          cfg_we,
	input  wire [bchd_pkg::CIDX_W-1:0]   cfg_index,
	input  wire [bchd_pkg::CFG_W-1:0]    cfg_data,
	input  wire                          button_a_level,
	input  wire                          button_b_level,
	input  wire                          power_off_request,
	input  wire [bchd_pkg::TIME_W-1:0]   now_ms,
	output logic                         a_pressed,
	output logic                         a_released,
	output logic [bchd_pkg::TIME_W-1:0]  a_hold_ms,
	output logic                         b_single_click,
	output logic                         b_double_click,
	output logic [bchd_pkg::TIME_W-1:0]  b_hold_ms,
	output logic                         hold_active,
	output logic [bchd_pkg::PROG_W-1:0]  hold_progress,
	output logic                         pairing_reset,
	output logic                         power_off,
	output logic                         any_event,
	output logic [bchd_pkg::CMD_W-1:0]   command
);
	import bchd_pkg::*;

	// configuration
	logic [CFG_W-1:0] window_q;
	logic [CFG_W-1:0] threshold_q;
	logic [CFG_W-1:0] delay_q;

	// button state
	logic              a_was_down_q;
	logic              b_was_down_q;
	logic              hold_reported_q;
	logic              click_pending_q;
	logic              second_click_q;
	logic [TIME_W-1:0] a_press_time_q;
	logic [TIME_W-1:0] b_press_time_q;
	logic [TIME_W-1:0] b_release_time_q;

	// captured sample
	logic              smp_a_q;
	logic              smp_b_q;
	logic              smp_pwr_q;
	logic [TIME_W-1:0] smp_now_q;

	// evaluated result
	logic              res_a_press_q;
	logic              res_a_rel_q;
	logic [TIME_W-1:0] res_a_hold_q;
	logic              res_single_q;
	logic              res_double_q;
	logic [TIME_W-1:0] res_b_hold_q;
	logic              res_active_q;
	logic              res_pairing_q;
	logic              res_pwr_q;

	// divider
	logic [CFG_W-1:0]  rem_q;
	logic [CFG_W-1:0]  quot_q;
	logic              sat_q;
	logic [DCNT_W-1:0] dcnt_q;

	// evaluation terms
	logic [CFG_W-1:0]  eff_delay;
	logic [CFG_W-1:0]  span;
	logic [TIME_W-1:0] win32;
	logic [TIME_W-1:0] thr32;
	logic              a_press;
	logic              a_rel;
	logic [TIME_W-1:0] a_ptime;
	logic [TIME_W-1:0] a_hold;
	logic              b_press;
	logic [TIME_W-1:0] b_ptime;
	logic [TIME_W-1:0] b_elapsed;
	logic [TIME_W-1:0] since_rel;
	logic [TIME_W-1:0] b_hold;
	logic              active;
	logic              single;
	logic              dbl;
	logic              pairing;
	logic              hr_n;
	logic              cp_n;
	logic              sc_n;
	logic [TIME_W-1:0] brt_n;
	logic [TIME_W-1:0] prog_diff;
	logic [CFG_W:0]    rem_shift;
	logic              rem_ge;
	logic [CMD_W-1:0]  cmd_code;

	assign eff_delay = (delay_q < threshold_q) ? delay_q : threshold_q;
	assign span      = threshold_q - eff_delay;
	assign win32     = {{(TIME_W-CFG_W){1'b0}}, window_q};
	assign thr32     = {{(TIME_W-CFG_W){1'b0}}, threshold_q};

	always_comb begin
		a_press   = smp_a_q && !a_was_down_q;
		a_rel     = !smp_a_q && a_was_down_q;
		a_ptime   = a_press ? smp_now_q : a_press_time_q;
		a_hold    = (smp_a_q || a_was_down_q) ? (smp_now_q - a_ptime) : '0;
		b_press   = smp_b_q && !b_was_down_q;
		b_ptime   = b_press ? smp_now_q : b_press_time_q;
		b_elapsed = smp_now_q - b_ptime;
		since_rel = smp_now_q - b_release_time_q;

		hr_n    = hold_reported_q;
		cp_n    = click_pending_q;
		sc_n    = second_click_q;
		brt_n   = b_release_time_q;
		single  = 1'b0;
		dbl     = 1'b0;
		pairing = 1'b0;
		active  = 1'b0;
		b_hold  = '0;

		// window ran out while b stays up
		if (!smp_b_q && !b_was_down_q && click_pending_q && (since_rel >= win32)) begin
			cp_n   = 1'b0;
			single = 1'b1;
		end

		if (b_press) begin
			hr_n = 1'b0;
			sc_n = click_pending_q && (since_rel <= win32);
			// press outside the window confirms the earlier click
			if (click_pending_q && !sc_n) begin
				cp_n   = 1'b0;
				single = 1'b1;
			end
		end

		if (smp_b_q) begin
			b_hold = b_elapsed;
			active = (b_hold >= {{(TIME_W-CFG_W){1'b0}}, eff_delay});
			if (!hr_n && (b_hold >= thr32)) begin
				hr_n    = 1'b1;
				cp_n    = 1'b0;
				sc_n    = 1'b0;
				pairing = 1'b1;
			end
		end else if (b_was_down_q) begin
			if (!hold_reported_q && (b_elapsed < thr32)) begin
				if (second_click_q) begin
					cp_n = 1'b0;
					dbl  = 1'b1;
				end else begin
					cp_n  = 1'b1;
					brt_n = smp_now_q;
				end
			end
			hr_n = 1'b0;
			sc_n = 1'b0;
		end
	end

	assign prog_diff = res_b_hold_q - {{(TIME_W-CFG_W){1'b0}}, eff_delay};
	assign rem_shift = {rem_q, 1'b0};
	assign rem_ge    = (rem_shift >= {1'b0, span});
	assign sts.div_last = (dcnt_q == DCNT_LAST);

	always_comb begin
		priority if (res_pwr_q) begin
			cmd_code = CMD_POWEROFF;
		end else if (res_pairing_q) begin
			cmd_code = CMD_PAIRING;
		end else if (res_double_q) begin
			cmd_code = CMD_LOCK;
		end else if (res_single_q) begin
			cmd_code = CMD_MIRROR;
		end else if (res_a_press_q) begin
			cmd_code = CMD_SHOOT;
		end else begin
			cmd_code = CMD_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q         <= WINDOW_RST;
			threshold_q      <= THRESHOLD_RST;
			delay_q          <= DELAY_RST;
			a_was_down_q     <= 1'b0;
			b_was_down_q     <= 1'b0;
			hold_reported_q  <= 1'b0;
			click_pending_q  <= 1'b0;
			second_click_q   <= 1'b0;
			a_press_time_q   <= '0;
			b_press_time_q   <= '0;
			b_release_time_q <= '0;
			dcnt_q           <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WINDOW:    window_q    <= cfg_data;
					REG_THRESHOLD: threshold_q <= cfg_data;
					REG_DELAY:     delay_q     <= cfg_data;
					default:       ;
				endcase
			end
			if (cmd.eval) begin
				a_was_down_q     <= smp_a_q;
				b_was_down_q     <= smp_b_q;
				hold_reported_q  <= hr_n;
				click_pending_q  <= cp_n;
				second_click_q   <= sc_n;
				a_press_time_q   <= a_ptime;
				b_press_time_q   <= b_ptime;
				b_release_time_q <= brt_n;
			end
			if (cmd.prep) begin
				dcnt_q <= '0;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			smp_a_q   <= button_a_level;
			smp_b_q   <= button_b_level;
			smp_pwr_q <= power_off_request;
			smp_now_q <= now_ms;
		end
		if (cmd.eval) begin
			res_a_press_q <= a_press;
			res_a_rel_q   <= a_rel;
			res_a_hold_q  <= a_hold;
			res_single_q  <= single;
			res_double_q  <= dbl;
			res_b_hold_q  <= b_hold;
			res_active_q  <= active;
			res_pairing_q <= pairing;
			res_pwr_q     <= smp_pwr_q;
		end
		if (cmd.prep) begin
			rem_q  <= prog_diff[CFG_W-1:0];
			quot_q <= '0;
			sat_q  <= (span == '0) || (prog_diff >= {{(TIME_W-CFG_W){1'b0}}, span});
		end else if (cmd.div_step) begin
			rem_q  <= rem_ge ? CFG_W'(rem_shift - {1'b0, span}) : rem_shift[CFG_W-1:0];
			quot_q <= {quot_q[CFG_W-2:0], rem_ge};
		end
		if (cmd.load_out) begin
			a_pressed      <= res_a_press_q;
			a_released     <= res_a_rel_q;
			a_hold_ms      <= res_a_hold_q;
			b_single_click <= res_single_q;
			b_double_click <= res_double_q;
			b_hold_ms      <= res_b_hold_q;
			hold_active    <= res_active_q;
			pairing_reset  <= res_pairing_q;
			power_off      <= res_pwr_q;
			any_event      <= res_a_press_q || res_a_rel_q || res_active_q || res_pairing_q
			                  || res_single_q || res_double_q || res_pwr_q;
			command        <= cmd_code;
			if (!res_active_q) begin
				hold_progress <= '0;
			end else if (sat_q) begin
				hold_progress <= Q16_ONE;
			end else begin
				hold_progress <= {1'b0, quot_q};
			end
		end
	end

	// the divider always starts from a fresh count
	a_prep_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.prep |=> (dcnt_q == '0))
		else $error("divider count not cleared by prep");

	// partial remainder stays below the divisor on the unsaturated path
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && !sat_q && res_active_q) |-> (rem_q < span))
		else $error("divider remainder out of range");

	// a pairing reset always marks the hold as reported
	a_pairing_hr: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.eval && pairing) |=> hold_reported_q)
		else $error("pairing reset without hold reported");

endmodule

`default_nettype wire

/* rtl/button_click_hold_detector.sv */
// top level of the button click / double-click / long-hold detector
// instantiates bchd_ctrl and bchd_dp; uses bchd_pkg
//
//  channel  handshake             payload
//  in       in_valid / in_stall   button_a_level, button_b_level, power_off_request, now_ms
//  out      out_valid / out_stall a_pressed .. command (one result per sample)
//  cfg      cfg_we                cfg_index, cfg_data (window, threshold, delay)
//
//  between its input transfer and out_valid a result passes evaluation, divider prep,
//  16 steps of the bit-serial progress divider, then the output load
//  a new sample is taken once the previous one has been loaded, so the block
//  does not take a new sample while it is still busy with the last one
//  reset clears the button state and restores window 300, threshold 3000, delay 500
//  a stalled result holds in the output register; the next sample is still
//  taken and waits before the output load until that result is transferred
`default_nettype none

module button_click_hold_detector (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [bchd_pkg::CIDX_W-1:0]   cfg_index,
	input  wire [bchd_pkg::CFG_W-1:0]    cfg_data,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire                          button_a_level,
	input  wire                          button_b_level,
	input  wire                          power_off_request,
	input  wire [bchd_pkg::TIME_W-1:0]   now_ms,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic                         a_pressed,
	output logic                         a_released,
	output logic [bchd_pkg::TIME_W-1:0]  a_hold_ms,
	output logic                         b_single_click,
	output logic                         b_double_click,
	output logic [bchd_pkg::TIME_W-1:0]  b_hold_ms,
	output logic                         hold_active,
	output logic [bchd_pkg::PROG_W-1:0]  hold_progress,
	output logic                         pairing_reset,
	output logic                         power_off,
	output logic                         any_event,
	output logic [bchd_pkg::CMD_W-1:0]   command
);
	import bchd_pkg::*;

	// command and status between controller and datapath
	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	// sequencing of capture, evaluation, division and output load
	bchd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (dp_cmd),
		.sts       (dp_sts)
	);

	// config registers, button state, event logic, divider and result register
	bchd_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (dp_cmd),
		.sts               (dp_sts),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.button_a_level    (button_a_level),
		.button_b_level    (button_b_level),
		.power_off_request (power_off_request),
		.now_ms            (now_ms),
		.a_pressed         (a_pressed),
		.a_released        (a_released),
		.a_hold_ms         (a_hold_ms),
		.b_single_click    (b_single_click),
		.b_double_click    (b_double_click),
		.b_hold_ms         (b_hold_ms),
		.hold_active       (hold_active),
		.hold_progress     (hold_progress),
		.pairing_reset     (pairing_reset),
		.power_off         (power_off),
		.any_event         (any_event),
		.command           (command)
	);

endmodule

`default_nettype wire
